// ===== design/kei_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the
// keyframe easing interpolator. No dependencies.
`default_nettype none
package kei_pkg;

  localparam int MAX_KEYS    = 16;
  localparam int KEY_IDX_W   = $clog2(MAX_KEYS);
  localparam int COUNT_W     = 5;
  localparam int TIME_BITS   = 24;
  localparam int VALUE_BITS  = 24;
  localparam int FRAC_BITS   = 16;
  localparam int T_W         = FRAC_BITS + 1;
  localparam int SINE_DEPTH  = 1024;
  localparam int SINE_SHIFT  = $clog2(SINE_DEPTH);
  localparam int SINE_AW     = $clog2(SINE_DEPTH + 1);
  localparam int EASE_W      = T_W + SINE_AW + 1;
  localparam int PROD_W      = VALUE_BITS + 1 + T_W + 1;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [0:0] {
    REQ_WRITE = 1'b0,
    REQ_EVAL  = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    EASE_LINEAR   = 2'd0,
    EASE_IN_SINE  = 2'd1,
    EASE_OUT_SINE = 2'd2,
    EASE_IN_OUT   = 2'd3
  } easing_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SPAN,
    ST_DIV,
    ST_EASE,
    ST_ROM,
    ST_MUL,
    ST_ROUND,
    ST_OUT
  } kei_state_t;

  // One keyframe entry
  typedef struct packed {
    logic [TIME_BITS-1:0]         ktime;
    logic signed [VALUE_BITS-1:0] kvalue;
    easing_t                      keasing;
  } kei_key_t;

  // Search probe that walks down the cell chain
  typedef struct packed {
    logic                         valid;
    logic                         found;
    logic [TIME_BITS-1:0]         now;
    logic [TIME_BITS-1:0]         prev_t;
    logic signed [VALUE_BITS-1:0] prev_v;
    logic [TIME_BITS-1:0]         from_t;
    logic signed [VALUE_BITS-1:0] from_v;
    logic [TIME_BITS-1:0]         to_t;
    logic signed [VALUE_BITS-1:0] to_v;
    easing_t                      to_e;
  } kei_probe_t;

  typedef logic [T_W-1:0] sine_rom_t [0:SINE_DEPTH];

  // Shift-subtract quotient, used only while the table is built
  function automatic longint unsigned udiv_const(longint unsigned num,
                                                 longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine quarter wave in Q16, Q30 Taylor series rounded to 16 fraction bits
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint unsigned x;
    longint unsigned term;
    longint unsigned r;
    longint sum;
    for (int j = 0; j <= SINE_DEPTH; j++) begin
      x = (HALF_PI_Q30 * longint'(j)) >> SINE_SHIFT;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 12; k++) begin
        term = (term * x) >> 30;
        term = udiv_const((term * x) >> 30, 64'((2 * k) * (2 * k + 1)));
        if ((k & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (longint'(sum) + 64'd8192) >> 14;
      if (r > 64'd65536) r = 64'd65536;
      rom[j] = T_W'(r);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage
`default_nettype wire

// ===== design/kei_sine_rom.sv =====
// Quarter-wave sine table with registered read.
// Depends on kei_pkg for the table contents.
`default_nettype none
module kei_sine_rom
  import kei_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [SINE_AW-1:0] addr,
  output logic      [T_W-1:0]     data
);

  // Register the table word
  always_ff @(posedge clk) begin
    if (addr > SINE_AW'(SINE_DEPTH)) data <= '0;
    else data <= SINE_ROM[addr];
  end

endmodule
`default_nettype wire

// ===== design/kei_key_cell.sv =====
// One keyframe cell: stores its entry and advances the search probe.
// Depends on kei_pkg.
`default_nettype none
module kei_key_cell
  import kei_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [KEY_IDX_W-1:0] cell_idx,
  input  wire logic [KEY_IDX_W-1:0] last_idx,
  input  wire logic                 wr_en,
  input  wire kei_key_t             wr_key,
  input  wire kei_probe_t           probe_in,
  output kei_probe_t                probe_out
);

  kei_key_t entry;
  logic     hit;

  // Hold the entry written to this cell
  always_ff @(posedge clk) begin
    if (wr_en) entry <= wr_key;
  end

  // Destination found here: this key lies after the time, or this is the last key (never cell 0)
  assign hit = probe_in.valid && !probe_in.found && (cell_idx != '0) &&
               ((probe_in.now < entry.ktime) || (cell_idx == last_idx));

  // Advance the probe one cell
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.found  <= probe_in.found | hit;
    probe_out.now    <= probe_in.now;
    probe_out.prev_t <= entry.ktime;
    probe_out.prev_v <= entry.kvalue;
    if (hit) begin
      probe_out.from_t <= probe_in.prev_t;
      probe_out.from_v <= probe_in.prev_v;
      probe_out.to_t   <= entry.ktime;
      probe_out.to_v   <= entry.kvalue;
      probe_out.to_e   <= entry.keasing;
    end else begin
      probe_out.from_t <= probe_in.from_t;
      probe_out.from_v <= probe_in.from_v;
      probe_out.to_t   <= probe_in.to_t;
      probe_out.to_v   <= probe_in.to_v;
      probe_out.to_e   <= probe_in.to_e;
    end
  end

endmodule
`default_nettype wire

// ===== design/kei_frac_div.sv =====
// Restoring divider for the segment fraction, one quotient bit a cycle.
// Depends on kei_pkg; expects 0 < num < den.
`default_nettype none
module kei_frac_div
  import kei_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [TIME_BITS-1:0] num,
  input  wire logic [TIME_BITS-1:0] den,
  output logic                      done,
  output logic      [FRAC_BITS-1:0] quo
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [TIME_BITS-1:0] rem;
  logic [TIME_BITS-1:0] dvs;
  logic [TIME_BITS:0]   rem2;
  logic                 ge;

  assign rem2 = {rem, 1'b0};
  assign ge   = rem2 >= {1'b0, dvs};

  // Control: count the quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift, compare, subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dvs <= den;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? TIME_BITS'(rem2 - {1'b0, dvs}) : TIME_BITS'(rem2);
      quo <= {quo[FRAC_BITS-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ===== design/keyframe_easing_interpolator_unit.sv =====
// Top level: keyframe table as a chain of cells, fraction divider, sine easing.
// Depends on kei_pkg, kei_key_cell, kei_frac_div, kei_sine_rom.
//
//  channel  | dir | payload (low bit first)
//  s_axis   | in  | tuser: req_type; tdata: key_index, key_time, key_value,
//           |     |   key_easing, anim_time, zero fill
//  m_axis   | out | tdata: result_value
//  cfg      | in  | cfg_wr_data: key_count (saturated to 2..16)
//
// A write beat is accepted in idle and the unit stays idle. An evaluate beat
// is accepted only in idle: the probe walks the key cells, then come the span
// check, the fraction divider, easing, sine read, multiply, rounding and output,
// and the unit returns to idle before it takes another beat. A clamped fraction
// skips the divider; a flat span goes straight to output.
// rst is synchronous; key contents are undefined until written.
// The result waits in an output register; a stalled result holds the next one.
`default_nettype none
module keyframe_easing_interpolator_unit
  import kei_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [79:0]        s_axis_tdata,  // key_index, key_time, key_value, key_easing, anim_time
  input  wire logic               s_axis_tuser,  // req_type
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [VALUE_BITS-1:0]   m_axis_tdata,  // result_value
  input  wire logic               cfg_wr_en,
  input  wire logic [COUNT_W-1:0] cfg_wr_data
);

  localparam int TD = TIME_BITS + 1;

  kei_state_t state, state_next;

  logic [COUNT_W-1:0]   key_count;
  logic                 in_acc;
  logic [KEY_IDX_W-1:0] in_idx;
  kei_key_t             in_key;
  logic [TIME_BITS-1:0] in_now;
  kei_probe_t           chain [0:MAX_KEYS];
  logic [KEY_IDX_W-1:0] last_idx;

  logic [TIME_BITS-1:0]         from_t, to_t, now;
  logic signed [VALUE_BITS-1:0] from_v, to_v;
  easing_t                      to_e;
  logic signed [TD-1:0]         nt, span;
  logic [T_W-1:0]               t;
  logic                         div_start, div_done;
  logic [FRAC_BITS-1:0]         div_quo;
  logic [EASE_W-1:0]            j_full, k_full;
  logic [SINE_AW-1:0]           rom_addr;
  logic [T_W-1:0]               rom_data;
  logic                         k_gt;
  logic [T_W:0]                 e_calc;
  logic [T_W-1:0]               e;
  logic signed [PROD_W-1:0]     prod;
  logic signed [PROD_W-1:0]     prod_rnd;
  logic signed [VALUE_BITS-1:0] res;

  // Unpack the input beat
  assign in_idx         = s_axis_tdata[KEY_IDX_W-1:0];
  assign in_key.ktime   = s_axis_tdata[4 +: TIME_BITS];
  assign in_key.kvalue  = s_axis_tdata[28 +: VALUE_BITS];
  assign in_key.keasing = easing_t'(s_axis_tdata[53:52]);
  assign in_now         = s_axis_tdata[54 +: TIME_BITS];
  assign in_acc         = s_axis_tvalid && s_axis_tready;

  // Key count register, saturated on write
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= COUNT_W'(2);
    end else if (cfg_wr_en) begin
      if (cfg_wr_data < COUNT_W'(2)) key_count <= COUNT_W'(2);
      else if (cfg_wr_data > COUNT_W'(MAX_KEYS)) key_count <= COUNT_W'(MAX_KEYS);
      else key_count <= cfg_wr_data;
    end
  end
  assign last_idx = KEY_IDX_W'(key_count - 1'b1);

  // Launch a probe at the head of the chain
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = in_acc && (s_axis_tuser == REQ_EVAL);
    chain[0].now   = in_now;
  end

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    kei_key_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (KEY_IDX_W'(i)),
      .last_idx (last_idx),
      .wr_en    (in_acc && (s_axis_tuser == REQ_WRITE) && (in_idx == KEY_IDX_W'(i))),
      .wr_key   (in_key),
      .probe_in (chain[i]),
      .probe_out(chain[i+1])
    );
  end

  // Segment offsets
  assign nt   = $signed({1'b0, now}) - $signed({1'b0, from_t});
  assign span = $signed({1'b0, to_t}) - $signed({1'b0, from_t});

  assign div_start = (state == ST_SPAN) && (span > 0) && (nt > 0) && (nt < span);

  kei_frac_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (TIME_BITS'(nt)),
    .den  (TIME_BITS'(span)),
    .done (div_done),
    .quo  (div_quo)
  );

  // Sine table index from the fraction
  assign j_full = (EASE_W'(t) * EASE_W'(SINE_DEPTH) + EASE_W'(32768)) >> FRAC_BITS;
  assign k_full = (EASE_W'(t) * EASE_W'(2 * SINE_DEPTH) + EASE_W'(32768)) >> FRAC_BITS;

  always_comb begin
    case (to_e)
      EASE_IN_SINE:  rom_addr = SINE_AW'(EASE_W'(SINE_DEPTH) - j_full);
      EASE_OUT_SINE: rom_addr = SINE_AW'(j_full);
      EASE_IN_OUT: begin
        if (k_full <= EASE_W'(SINE_DEPTH)) rom_addr = SINE_AW'(EASE_W'(SINE_DEPTH) - k_full);
        else rom_addr = SINE_AW'(k_full - EASE_W'(SINE_DEPTH));
      end
      default: rom_addr = '0;
    endcase
  end

  // Table word is registered at the end of the ease cycle
  kei_sine_rom u_rom (
    .clk (clk),
    .addr(rom_addr),
    .data(rom_data)
  );

  // Shape the fraction
  always_comb begin
    case (to_e)
      EASE_IN_SINE:  e_calc = (T_W+1)'(65536) - {1'b0, rom_data};
      EASE_OUT_SINE: e_calc = {1'b0, rom_data};
      EASE_IN_OUT: begin
        if (k_gt) e_calc = ((T_W+1)'(65536) + {1'b0, rom_data} + 1'b1) >> 1;
        else e_calc = ((T_W+1)'(65536) - {1'b0, rom_data} + 1'b1) >> 1;
      end
      default: e_calc = {1'b0, t};
    endcase
  end

  assign prod_rnd = (prod + PROD_W'(32768)) >>> FRAC_BITS;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Next state and input ready
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && (s_axis_tuser == REQ_EVAL)) state_next = ST_SEARCH;
      end
      ST_SEARCH: if (chain[MAX_KEYS].valid) state_next = ST_SPAN;
      ST_SPAN: begin
        if (span <= 0) state_next = ST_OUT;
        else if (div_start) state_next = ST_DIV;
        else state_next = ST_EASE;
      end
      ST_DIV:   if (div_done) state_next = ST_EASE;
      ST_EASE:  state_next = ST_ROM;
      ST_ROM:   state_next = ST_MUL;
      ST_MUL:   state_next = ST_ROUND;
      ST_ROUND: state_next = ST_OUT;
      ST_OUT:   if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_SEARCH: begin
        now    <= chain[MAX_KEYS].now;
        from_t <= chain[MAX_KEYS].from_t;
        from_v <= chain[MAX_KEYS].from_v;
        to_t   <= chain[MAX_KEYS].to_t;
        to_v   <= chain[MAX_KEYS].to_v;
        to_e   <= chain[MAX_KEYS].to_e;
      end
      ST_SPAN: begin
        if (span <= 0) res <= to_v;
        else if (nt <= 0) t <= '0;
        else if (nt >= span) t <= T_W'(65536);
      end
      ST_DIV: if (div_done) t <= {1'b0, div_quo};
      ST_EASE: k_gt <= k_full > EASE_W'(SINE_DEPTH);
      ST_ROM: e <= T_W'(e_calc);
      ST_MUL: prod <= PROD_W'((VALUE_BITS+1)'(to_v) - (VALUE_BITS+1)'(from_v)) *
                      $signed({1'b0, e});
      ST_ROUND: res <= VALUE_BITS'(PROD_W'(from_v) + prod_rnd);
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_OUT) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && (!m_axis_tvalid || m_axis_tready)) m_axis_tdata <= res;
  end

  // Checks
  logic [MAX_KEYS-1:0] probe_live;
  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_live
    assign probe_live[i] = chain[i+1].valid;
  end

  a_one_probe: assert property (@(posedge clk) disable iff (rst) $onehot0(probe_live))
    else $error("more than one probe in the key chain");
  a_probe_state: assert property (@(posedge clk) disable iff (rst)
    chain[MAX_KEYS].valid |-> (state == ST_SEARCH))
    else $error("probe left the chain outside search");
  a_probe_found: assert property (@(posedge clk) disable iff (rst)
    chain[MAX_KEYS].valid |-> chain[MAX_KEYS].found)
    else $error("probe left the chain without a segment");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (key_count >= COUNT_W'(2)) && (key_count <= COUNT_W'(MAX_KEYS)))
    else $error("key count out of range");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside divide state");

endmodule
`default_nettype wire
